@@ rtl/sttab_pkg.sv @@
`timescale 1ns / 1ps

package sttab_pkg;

  localparam int DepthDefault = 10;
  localparam int CntW         = 4;
  localparam int NameBytes    = 6;
  localparam int ScoreW       = 32;
  localparam int NameW        = 8 * NameBytes;
  localparam int StageW       = 8;
  localparam int LapW         = 8;
  localparam int ModeW        = 2;
  localparam int StatusW      = 2;

  localparam logic [ModeW-1:0] MODE_CHECK  = 2'd0;
  localparam logic [ModeW-1:0] MODE_INSERT = 2'd1;
  localparam logic [ModeW-1:0] MODE_READ   = 2'd2;

  localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_BAD_SLOT = 2'd1;
  localparam logic [StatusW-1:0] STATUS_BAD_READ = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_INS_RD,
    ST_INS_WR,
    ST_RD_WAIT
  } state_e;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [NameW-1:0]  name;
    logic [StageW-1:0] stage;
    logic [LapW-1:0]   lap;
  } entry_t;

  typedef struct packed {
    logic [CntW-1:0]    position;
    logic               ranked;
    logic [StatusW-1:0] status;
    logic [CntW-1:0]    entry_count;
    entry_t             entry;
  } result_t;

  // Keep name bytes up to the first zero byte, clear everything after it.
  function automatic logic [NameW-1:0] clean_name(input logic [NameW-1:0] raw);
    logic             keep;
    logic [NameW-1:0] kept;
    keep = 1'b1;
    kept = '0;
    for (int b = 0; b < NameBytes; b++) begin
      if (raw[8*b +: 8] == 8'h00) keep = 1'b0;
      if (keep) kept[8*b +: 8] = raw[8*b +: 8];
    end
    return kept;
  endfunction

endpackage

@@ rtl/sttab_ram.sv @@
`timescale 1ns / 1ps

module sttab_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sorted_top_k_score_table_unit.sv @@
`timescale 1ns / 1ps

// Sorted top-K score table: up to DEPTH entries kept in descending score order.
// Command channel: a request (mode, score, name, stage, lap, slot) is taken at
// a rising edge where start_i is high and busy_o is low. busy_o stays high
// while the sequencer works on it; no further request is taken meanwhile.
// Result channel: result_valid_o is high for exactly one cycle, the cycle after
// the last busy cycle (or after the transfer when no busy cycle is needed), with
// every result field valid in that cycle. The receiver cannot stall; a result
// not taken in its strobe cycle is lost.
// Sequencing: entries live in one RAM with a registered read port and are
// visited one at a time through a single comparator. A check walks down from the
// top through CHK_RD and CHK_CMP for each entry examined; an insert moves entries
// down from the new last slot through INS_RD and INS_WR for each, then writes the
// new entry in INS_RD; a read waits in RD_WAIT for the RAM. A check of an empty
// table, a rejected or an unknown request needs no busy state. busy_o is low in
// the strobe cycle, and a new request may be started in it.
// Reset: the entry count clears at once, the sequencer returns to idle and no
// result is pending. The RAM is not cleared; entries beyond the count are never
// read, so no clearing pass is needed.

module sorted_top_k_score_table_unit #(
  parameter int DEPTH = sttab_pkg::DepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [sttab_pkg::ModeW-1:0]     mode_i,
  input  logic [sttab_pkg::ScoreW-1:0]    new_score_i,
  input  logic [sttab_pkg::NameW-1:0]     player_name_i,
  input  logic [sttab_pkg::StageW-1:0]    stage_number_i,
  input  logic [sttab_pkg::LapW-1:0]      lap_number_i,
  input  logic [sttab_pkg::CntW-1:0]      slot_i,
  output logic                            result_valid_o,
  output logic [sttab_pkg::CntW-1:0]      position_o,
  output logic                            ranked_o,
  output logic [sttab_pkg::StatusW-1:0]   status_o,
  output logic [sttab_pkg::CntW-1:0]      entry_count_o,
  output logic [sttab_pkg::ScoreW-1:0]    read_score_o,
  output logic [sttab_pkg::NameW-1:0]     read_name_o,
  output logic [sttab_pkg::StageW-1:0]    read_stage_o,
  output logic [sttab_pkg::LapW-1:0]      read_lap_o
);

  localparam int CntW  = sttab_pkg::CntW;
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EntW  = $bits(sttab_pkg::entry_t);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);
  localparam logic [CntW-1:0] One    = CntW'(1);

  sttab_pkg::state_e  state_q, state_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    slot_q;
  sttab_pkg::entry_t  new_q;
  sttab_pkg::result_t res_q, res_d;
  logic               res_valid_q, res_valid_d;

  // RAM side
  logic                we;
  logic [CntW-1:0]     waddr_full, raddr_full;
  sttab_pkg::entry_t   wdata, rdata;
  logic [EntW-1:0]     rdata_raw;

  // Finishing values for the result of the current request
  logic                        fin;
  logic [CntW-1:0]             fin_pos;
  logic                        fin_ranked;
  logic [sttab_pkg::StatusW-1:0] fin_status;
  sttab_pkg::entry_t           fin_entry;

  logic accept;
  logic score_wins;

  assign accept     = start_i && (state_q == sttab_pkg::ST_IDLE);
  assign rdata      = sttab_pkg::entry_t'(rdata_raw);
  // The one shared comparator: new score against the entry just read.
  assign score_wins = new_q.score > rdata.score;

  sttab_ram #(
    .Width (EntW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr_full[AddrW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr_full[AddrW-1:0]),
    .rdata_o (rdata_raw)
  );

  // Capture the request; the name is cleaned on the way in.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      new_q.score <= new_score_i;
      new_q.name  <= sttab_pkg::clean_name(player_name_i);
      new_q.stage <= stage_number_i;
      new_q.lap   <= lap_number_i;
      slot_q      <= slot_i;
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sttab_pkg::ST_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    count_d    = count_q;
    we         = 1'b0;
    waddr_full = idx_q;
    wdata      = rdata;
    raddr_full = idx_q;
    fin        = 1'b0;
    fin_pos    = DepthC;
    fin_ranked = 1'b0;
    fin_status = sttab_pkg::STATUS_OK;
    fin_entry  = '0;

    unique case (state_q)
      sttab_pkg::ST_IDLE: begin
        raddr_full = slot_i;
        if (start_i) begin
          case (mode_i)
            sttab_pkg::MODE_CHECK: begin
              if (count_q == '0) begin
                // Empty table: any score enters at the top
                fin        = 1'b1;
                fin_pos    = '0;
                fin_ranked = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = sttab_pkg::ST_CHK_RD;
              end
            end
            sttab_pkg::MODE_INSERT: begin
              if (slot_i > count_q || slot_i >= DepthC) begin
                fin        = 1'b1;
                fin_status = sttab_pkg::STATUS_BAD_SLOT;
              end else begin
                // Start at the new last slot; a full table drops its tail
                idx_d   = (count_q < DepthC) ? count_q : DepthC - One;
                state_d = sttab_pkg::ST_INS_RD;
              end
            end
            sttab_pkg::MODE_READ: begin
              if (slot_i < count_q) begin
                state_d = sttab_pkg::ST_RD_WAIT;
              end else begin
                fin        = 1'b1;
                fin_status = sttab_pkg::STATUS_BAD_READ;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      sttab_pkg::ST_CHK_RD: begin
        state_d = sttab_pkg::ST_CHK_CMP;
      end
      sttab_pkg::ST_CHK_CMP: begin
        if (score_wins) begin
          fin        = 1'b1;
          fin_pos    = idx_q;
          fin_ranked = 1'b1;
        end else if (idx_q + One >= count_q) begin
          // Past the last entry: rank at the end only if there is room
          fin = 1'b1;
          if (count_q < DepthC) begin
            fin_pos    = count_q;
            fin_ranked = 1'b1;
          end
        end else begin
          idx_d   = idx_q + One;
          state_d = sttab_pkg::ST_CHK_RD;
        end
      end
      sttab_pkg::ST_INS_RD: begin
        if (idx_q > slot_q) begin
          raddr_full = idx_q - One;
          state_d    = sttab_pkg::ST_INS_WR;
        end else begin
          we      = 1'b1;
          wdata   = new_q;
          count_d = (count_q < DepthC) ? count_q + One : count_q;
          fin     = 1'b1;
        end
      end
      sttab_pkg::ST_INS_WR: begin
        // Move the entry above down by one
        we      = 1'b1;
        wdata   = rdata;
        idx_d   = idx_q - One;
        state_d = sttab_pkg::ST_INS_RD;
      end
      sttab_pkg::ST_RD_WAIT: begin
        fin       = 1'b1;
        fin_entry = rdata;
      end
      default: begin
        state_d = sttab_pkg::ST_IDLE;
      end
    endcase

    if (fin) state_d = sttab_pkg::ST_IDLE;

    res_valid_d = fin;
    res_d       = res_q;
    if (fin) begin
      res_d.position    = fin_pos;
      res_d.ranked      = fin_ranked;
      res_d.status      = fin_status;
      res_d.entry_count = count_d;
      res_d.entry       = fin_entry;
    end
  end

  assign busy_o         = (state_q != sttab_pkg::ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign position_o     = res_q.position;
  assign ranked_o       = res_q.ranked;
  assign status_o       = res_q.status;
  assign entry_count_o  = res_q.entry_count;
  assign read_score_o   = res_q.entry.score;
  assign read_name_o    = res_q.entry.name;
  assign read_stage_o   = res_q.entry.stage;
  assign read_lap_o     = res_q.entry.lap;

  // The table never holds more than DEPTH entries.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count beyond table depth");

  // A result comes only from a request that was started or in progress.
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(start_i || (state_q != sttab_pkg::ST_IDLE)))
    else $error("result strobe without a request");

  // The count only ever grows, by one, and only on a finishing insert.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + One) && res_valid_q)
    else $error("entry count changed unexpectedly");

  // A ranked check always names a slot inside the table.
  a_ranked_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.ranked) |-> (res_q.position < DepthC))
    else $error("ranked result with position outside the table");

endmodule
